/* src/fqd_pkg.sv */
package fqd_pkg;

    // default geometry
    localparam int DEPTH_DEF      = 16;
    localparam int ITEM_WIDTH_DEF = 32;

    // field widths fixed by the request and result formats
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_DELETE  = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    // per-cell control from the queue controller to each cell
    typedef struct packed {
        logic occupied;   // cell holds a live entry
        logic load;       // cell takes the incoming item
        logic dequeue;    // whole row shifts toward the head
        logic delete_en;  // cells at or past the first match shift toward the head
    } cell_ctrl_t;

endpackage

/* src/fqd_cell.sv */
module fqd_cell
    import fqd_pkg::*;
#(
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
    input  logic                  aclk,
    input  cell_ctrl_t            ctrl,
    input  logic [ITEM_WIDTH-1:0] item,
    input  logic [ITEM_WIDTH-1:0] next_data,  // entry of the neighbor toward the tail
    input  logic                  hit_in,     // a match exists nearer the head
    output logic [ITEM_WIDTH-1:0] data,
    output logic                  hit_out
);

    logic [ITEM_WIDTH-1:0] entry_reg;
    logic [ITEM_WIDTH-1:0] entry_next;
    logic                  match;
    logic                  shift;

    assign match   = ctrl.occupied && (entry_reg == item);
    assign hit_out = hit_in | match;
    assign shift   = ctrl.dequeue | (ctrl.delete_en & hit_out);

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.load) begin
            entry_next = item;
        end else if (shift) begin
            entry_next = next_data;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign data = entry_reg;

endmodule

/* src/fifo_queue_with_delete_unit.sv */
// bounded fifo of non-zero item tags with delete-by-value. each request beat
// carries an operation in s_tuser (enqueue, dequeue, delete, or the spare code
// as a no-op) and an item tag in s_tdata; each request yields exactly one
// result beat with status, the dequeued item (zero otherwise) and the queue
// length after the request. on any error the queue is left untouched. the
// entries live in a row of DEPTH cells, head at cell 0; all cells compare
// against the request item at once and a hit signal ripples down the row, so
// a delete closes the gap by shifting every cell at or past the first match
// one place toward the head in the same cycle. the compare and hit ripple
// through the cell row are combinational, and a new request is taken every
// cycle as long as the result register is free or being drained. no clearing
// pass is needed after reset: only the entry count and result valid are reset
module fifo_queue_with_delete_unit
    import fqd_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int IN_W      = ((ITEM_WIDTH + 7) / 8) * 8,
    localparam int RES_W     = STATUS_W + ITEM_WIDTH + CNT_W,
    localparam int OUT_W     = ((RES_W + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    // request channel
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // item
    input  logic [OP_W-1:0]  s_tuser,   // operation
    // result channel
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, item_out, length
);

    // request decode
    logic                  s_accept;
    op_t                   op;
    logic [ITEM_WIDTH-1:0] item;
    logic                  item_null;
    logic                  is_empty;
    logic                  is_full;

    // queue occupancy
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // result register
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    status_t               m_status_reg;
    logic [ITEM_WIDTH-1:0] m_item_reg;
    logic [CNT_W-1:0]      m_len_reg;

    // operation outcomes
    logic    enq_ok;
    logic    deq_ok;
    logic    del_try;
    logic    del_found;
    status_t status;

    // cell row wiring
    cell_ctrl_t            ctrl [DEPTH];
    logic [ITEM_WIDTH-1:0] cell_data [DEPTH];
    logic [ITEM_WIDTH-1:0] cell_next [DEPTH];
    logic [DEPTH:0]        hit;
    logic [DEPTH-1:0]      load_vec;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign op        = op_t'(s_tuser);
    assign item      = s_tdata[ITEM_WIDTH-1:0];
    assign item_null = (item == '0);
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CNT_W'(DEPTH));

    // outcome of the request; errors leave the row and the count alone
    always_comb begin
        enq_ok  = 1'b0;
        deq_ok  = 1'b0;
        del_try = 1'b0;
        status  = ST_OK;
        case (op)
            OP_ENQUEUE: begin
                if (item_null) begin
                    status = ST_NULL;
                end else if (is_full) begin
                    status = ST_FULL;
                end else begin
                    enq_ok = s_accept;
                end
            end
            OP_DEQUEUE: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    deq_ok = s_accept;
                end
            end
            OP_DELETE: begin
                if (item_null) begin
                    status = ST_NULL;
                end else if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    del_try = s_accept;
                    if (!hit[DEPTH]) begin
                        status = ST_NOT_FOUND;
                    end
                end
            end
            default: begin
                status = ST_OK;  // spare code, nothing happens
            end
        endcase
    end

    assign del_found = del_try && hit[DEPTH];

    // cell row, head at index 0; hit ripples from head toward tail
    assign hit[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign ctrl[i].occupied  = (CNT_W'(i) < count_reg);
        assign ctrl[i].load      = enq_ok && (count_reg == CNT_W'(i));
        assign ctrl[i].dequeue   = deq_ok;
        assign ctrl[i].delete_en = del_try;
        assign load_vec[i]       = ctrl[i].load;

        // the tail cell refills from itself; anything past the count is dead
        if (i == DEPTH - 1) begin : g_tail
            assign cell_next[i] = cell_data[i];
        end else begin : g_body
            assign cell_next[i] = cell_data[i+1];
        end

        fqd_cell #(
            .ITEM_WIDTH (ITEM_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl[i]),
            .item      (item),
            .next_data (cell_next[i]),
            .hit_in    (hit[i]),
            .data      (cell_data[i]),
            .hit_out   (hit[i+1])
        );
    end

    // entry count
    always_comb begin
        count_next = count_reg;
        if (enq_ok) begin
            count_next = count_reg + CNT_W'(1);
        end else if (deq_ok || del_found) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (s_accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload, loaded on every accepted request beat
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_status_reg <= status;
            m_item_reg   <= deq_ok ? cell_data[0] : '0;
            m_len_reg    <= count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({m_len_reg, m_item_reg, m_status_reg});

    // the count never runs past the row
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    // the reported length is the count the row holds afterwards
    a_len_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_len_reg == count_reg)
        else $error("result length differs from entry count");

    // a successful dequeue shortens the queue by one
    a_deq_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        deq_ok |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("dequeue did not shorten the queue");

    // at most one cell loads per beat, and never alongside a shift
    a_single_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(load_vec) && !(enq_ok && (deq_ok || del_try)))
        else $error("conflicting cell row controls");

endmodule
